// ----- sv/tmpb_pkg.sv -----
// ----------------------------------------------------------------------------
// tmpb_pkg
// Shared types and constants of the tile map pixel blender.
// ----------------------------------------------------------------------------
package tmpb_pkg;

  // field widths
  localparam int CMD_W      = 1;
  localparam int CODE_W     = 3;
  localparam int SLOT_W     = 12;
  localparam int COORD_W    = 12;
  localparam int CH_W       = 8;
  localparam int COLOUR_W   = 24;
  localparam int ALPHA_W    = 9;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // reciprocal of the tile edge, scaled by 2^RECIP_SHIFT
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 20;
  localparam int STEP_W      = 5;
  localparam int WHERE_W     = 19;

  // result queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = 3;
  localparam int CRED_W    = 4;

  // commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SHADE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = 2'd2;

  // configuration reset values
  localparam logic [DIM_W-1:0]   TILE_PIXELS_RST = 7'd10;
  localparam logic [DIM_W-1:0]   MAP_COLUMNS_RST = 7'd16;
  localparam logic [ALPHA_W-1:0] BLEND_ALPHA_RST = 9'd0;

  // tile codes
  localparam logic [CODE_W-1:0] TILE_WALL     = 3'd1;
  localparam logic [CODE_W-1:0] TILE_FLOOR    = 3'd2;
  localparam logic [CODE_W-1:0] TILE_ENTRANCE = 3'd3;
  localparam logic [CODE_W-1:0] TILE_EXIT     = 3'd4;

  // colour levels and blend constants
  localparam logic [CH_W-1:0]    WHITE_LEVEL = 8'hff;
  localparam logic [CH_W-1:0]    WALL_LEVEL  = 8'h22;
  localparam logic [CH_W-1:0]    ROUND_HALF  = 8'h80;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;

  typedef struct packed {
    logic               busy;
    logic [RECIP_W-1:0] value;
  } recip_status_t;

endpackage

// ----- sv/tmpb_recip.sv -----
// ----------------------------------------------------------------------------
// tmpb_recip
// Bit-serial divider giving ceil(2^19 / divisor), one quotient bit per clock.
// ----------------------------------------------------------------------------
module tmpb_recip import tmpb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIM_W-1:0]    divisor,
  output recip_status_t       status
);

  logic               busy_r;
  logic [STEP_W-1:0]  step_r;
  logic [RECIP_W-1:0] num_r;
  logic [DIM_W-1:0]   rem_r;
  logic [DIM_W-1:0]   div_r;
  logic [RECIP_W-1:0] quo_r;

  logic [DIM_W:0]     rem_sh;
  logic               fits;
  logic [DIM_W-1:0]   rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, num_r[RECIP_W-1]};
    fits    = rem_sh >= {1'b0, div_r};
    rem_nxt = fits ? DIM_W'(rem_sh - {1'b0, div_r}) : DIM_W'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(RECIP_W);
    end else if (busy_r) begin
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // ceiling taken as floor((2^19 + d - 1) / d)
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= (RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(divisor) - RECIP_W'(1);
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[RECIP_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[RECIP_W-2:0], fits};
    end
  end

  assign status.busy  = busy_r;
  assign status.value = quo_r;

endmodule

// ----- sv/tile_map_pixel_blender.sv -----
// ----------------------------------------------------------------------------
// tile_map_pixel_blender
// Tile map store with per-pixel tile lookup and alpha blend over RGB888.
// ----------------------------------------------------------------------------
// path: a shade result passes stages a, b, c and d and the result queue
//   before it reaches the out_ ports; write beats give no result
// throughput: one beat per clock while in_ready holds; the tile map is one
//   single-port memory used once per beat in the lookup stage
// reset: clears control state, then holds in_ready low while the tile edge
//   reciprocal is formed; a write to tile_pixels does the same
module tile_map_pixel_blender import tmpb_pkg::*; #(
  parameter int MAP_ENTRIES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [SLOT_W-1:0]     in_tile_slot,
  input  logic [CODE_W-1:0]     in_tile_code,
  input  logic [COORD_W-1:0]    in_pixel_col,
  input  logic [COORD_W-1:0]    in_pixel_row,
  input  logic [COLOUR_W-1:0]   in_old_colour,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOUR_W-1:0]   out_new_colour,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAP_ENTRIES);

  function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0]    old,
                                               input logic [CH_W-1:0]    level,
                                               input logic [ALPHA_W-1:0] alpha);
    logic signed [CH_W+1:0]  diff;
    logic signed [2*CH_W+3:0] prod;
    logic signed [2*CH_W+3:0] acc;
    diff = $signed({2'b00, level}) - $signed({2'b00, old});
    prod = $signed({1'b0, alpha}) * diff;
    acc  = $signed({4'b0000, old, ROUND_HALF}) + prod;
    return acc[2*CH_W-1:CH_W];
  endfunction

  // configuration
  logic [DIM_W-1:0]   tile_pixels_r;
  logic [DIM_W-1:0]   map_columns_r;
  logic [ALPHA_W-1:0] blend_alpha_r;
  logic               recip_start_r;
  logic [DIM_W-1:0]   edge_len;
  logic [ALPHA_W-1:0] alpha_eff;
  recip_status_t      recip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_pixels_r <= TILE_PIXELS_RST;
      map_columns_r <= MAP_COLUMNS_RST;
      blend_alpha_r <= BLEND_ALPHA_RST;
      recip_start_r <= 1'b1;
    end else begin
      recip_start_r <= cfg_we && (cfg_index == CFG_TILE_PIXELS);
      if (cfg_we) begin
        case (cfg_index)
          CFG_TILE_PIXELS: tile_pixels_r <= cfg_data[DIM_W-1:0];
          CFG_MAP_COLUMNS: map_columns_r <= cfg_data[DIM_W-1:0];
          CFG_BLEND_ALPHA: blend_alpha_r <= cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign edge_len  = (tile_pixels_r == '0) ? DIM_W'(1) : tile_pixels_r;
  assign alpha_eff = (blend_alpha_r > ALPHA_ONE) ? ALPHA_ONE : blend_alpha_r;

  tmpb_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (recip_start_r),
    .divisor (edge_len),
    .status  (recip)
  );

  // input acceptance against result queue credits
  logic              in_acc;
  logic              out_pop;
  logic [CRED_W-1:0] cred_r;
  logic [CRED_W-1:0] cred_nxt;

  assign in_ready = !recip_start_r && !recip.busy && (cred_r < CRED_W'(OUT_DEPTH));
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    cred_nxt = cred_r;
    if (in_acc && (in_command == CMD_SHADE)) begin
      cred_nxt = cred_nxt + CRED_W'(1);
    end
    if (out_pop) begin
      cred_nxt = cred_nxt - CRED_W'(1);
    end
  end

  // stage a: input beat
  logic               a_v_r;
  logic [CMD_W-1:0]   a_cmd_r;
  logic [SLOT_W-1:0]  a_slot_r;
  logic [CODE_W-1:0]  a_code_r;
  logic [COORD_W-1:0] a_col_r;
  logic [COORD_W-1:0] a_row_r;
  logic [COLOUR_W-1:0] a_old_r;

  // stage b: tile coordinates
  logic                 b_v_r;
  logic [CMD_W-1:0]     b_cmd_r;
  logic [SLOT_W-1:0]    b_slot_r;
  logic [CODE_W-1:0]    b_code_r;
  logic [COORD_W-1:0]   b_qcol_r;
  logic [COORD_W-1:0]   b_qrow_r;
  logic [COLOUR_W-1:0]  b_old_r;
  logic [COORD_W+RECIP_W-1:0] prod_col;
  logic [COORD_W+RECIP_W-1:0] prod_row;

  // stage c: memory address
  logic                c_v_r;
  logic [CMD_W-1:0]    c_cmd_r;
  logic                c_ok_r;
  logic [ADDR_W-1:0]   c_addr_r;
  logic [CODE_W-1:0]   c_code_r;
  logic [COLOUR_W-1:0] c_old_r;
  logic [WHERE_W-1:0]  where;

  // stage d: memory data and blend
  logic                d_v_r;
  logic                d_hit_r;
  logic [COLOUR_W-1:0] d_old_r;
  logic [CODE_W-1:0]   mem_q_r;
  logic [CODE_W-1:0]   d_code;
  logic [CH_W-1:0]     level;
  logic                lit;
  logic [COLOUR_W-1:0] shade;

  logic [CODE_W-1:0] tile_mem [MAP_ENTRIES];

  // quotient by reciprocal; exact for 12-bit coordinates and edges below 128
  assign prod_col = COORD_W'(a_col_r) * recip.value;
  assign prod_row = COORD_W'(a_row_r) * recip.value;

  assign where = WHERE_W'(b_qrow_r * map_columns_r) + WHERE_W'(b_qcol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      cred_r <= '0;
    end else begin
      a_v_r  <= in_acc;
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      d_v_r  <= c_v_r && (c_cmd_r == CMD_SHADE);
      cred_r <= cred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_cmd_r  <= in_command;
    a_slot_r <= in_tile_slot;
    a_code_r <= in_tile_code;
    a_col_r  <= in_pixel_col;
    a_row_r  <= in_pixel_row;
    a_old_r  <= in_old_colour;

    b_cmd_r  <= a_cmd_r;
    b_slot_r <= a_slot_r;
    b_code_r <= a_code_r;
    b_qcol_r <= prod_col[RECIP_SHIFT +: COORD_W];
    b_qrow_r <= prod_row[RECIP_SHIFT +: COORD_W];
    b_old_r  <= a_old_r;

    c_cmd_r  <= b_cmd_r;
    c_code_r <= b_code_r;
    c_old_r  <= b_old_r;
    if (b_cmd_r == CMD_WRITE) begin
      c_ok_r   <= WHERE_W'(b_slot_r) < WHERE_W'(MAP_ENTRIES);
      c_addr_r <= ADDR_W'(b_slot_r);
    end else begin
      c_ok_r   <= where < WHERE_W'(MAP_ENTRIES);
      c_addr_r <= ADDR_W'(where);
    end

    d_hit_r <= c_ok_r;
    d_old_r <= c_old_r;
  end

  // one access per beat in program order, so a read always sees earlier writes
  always_ff @(posedge clk) begin
    if (c_v_r && c_ok_r && (c_cmd_r == CMD_WRITE)) begin
      tile_mem[c_addr_r] <= c_code_r;
    end
    mem_q_r <= tile_mem[c_addr_r];
  end

  assign d_code = d_hit_r ? mem_q_r : '0;

  always_comb begin
    case (d_code)
      TILE_FLOOR, TILE_ENTRANCE, TILE_EXIT: begin
        level = WHITE_LEVEL;
        lit   = 1'b1;
      end
      TILE_WALL: begin
        level = WALL_LEVEL;
        lit   = 1'b1;
      end
      default: begin
        level = '0;
        lit   = 1'b0;
      end
    endcase
    if (lit) begin
      shade = {blend_ch(d_old_r[2*CH_W +: CH_W], level, alpha_eff),
               blend_ch(d_old_r[CH_W +: CH_W], level, alpha_eff),
               blend_ch(d_old_r[0 +: CH_W], level, alpha_eff)};
    end else begin
      shade = '0;
    end
  end

  // result queue
  logic [COLOUR_W-1:0] q_data [OUT_DEPTH];
  logic [OUT_PTR_W:0]  wr_ptr_r;
  logic [OUT_PTR_W:0]  rd_ptr_r;

  assign out_valid      = wr_ptr_r != rd_ptr_r;
  assign out_pop        = out_valid && out_ready;
  assign out_new_colour = q_data[rd_ptr_r[OUT_PTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (d_v_r) begin
        wr_ptr_r <= wr_ptr_r + (OUT_PTR_W+1)'(1);
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + (OUT_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_v_r) begin
      q_data[wr_ptr_r[OUT_PTR_W-1:0]] <= shade;
    end
  end

endmodule

// ----- sv/tmpb_checker.sv -----
// ----------------------------------------------------------------------------
// tmpb_checker
// Port-level checks of the tile map pixel blender, bound to the top level.
// ----------------------------------------------------------------------------
module tmpb_checker import tmpb_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [CMD_W-1:0]     in_command,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [COLOUR_W-1:0]  out_new_colour,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // queue empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // reciprocal is being formed after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // a new tile edge stalls input while the reciprocal is redone
  a_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == CFG_TILE_PIXELS) |=> !in_ready)
    else $error("input ready right after tile edge write");

  // every shade beat reaches the output within the pipeline depth
  a_shade_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_SHADE) |-> ##5 out_valid)
    else $error("shade result missing after pipeline latency");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_colour))
    else $error("stalled result beat changed");

endmodule

bind tile_map_pixel_blender tmpb_checker u_tmpb_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tile map pixel blender. Tile writes and pixel
// shades stream in over a bursty valid/ready channel while the result side
// stalls on a rotating pattern. A scoreboard keeps its own copy of the tile
// map and registers, works out each blended colour and checks every result
// beat in order. Shades only touch map entries already written, or fall off
// the end of the map. Register settings change between idle phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tmpb_pkg::*;

  localparam int MAP_ENTRIES    = 4096;
  localparam int COORD_MAX      = 4095;
  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 6;
  localparam int FILL_BEATS     = 32;
  localparam int MIX_BEATS      = 268;

  localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 2'd3;

  class colour_scoreboard;
    logic [DIM_W-1:0]    tile_px;
    logic [DIM_W-1:0]    map_cols;
    logic [ALPHA_W-1:0]  blend_alpha;
    logic [CODE_W-1:0]   tile_codes [MAP_ENTRIES];
    bit                  tile_set [MAP_ENTRIES];
    int                  set_slots [$];
    logic [COLOUR_W-1:0] colours_due [$];
    int                  errors;
    int                  checked;

    function new();
      tile_px     = TILE_PIXELS_RST;
      map_cols    = MAP_COLUMNS_RST;
      blend_alpha = BLEND_ALPHA_RST;
      foreach (tile_set[i]) tile_set[i] = 1'b0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TILE_PIXELS: tile_px = data[DIM_W-1:0];
        CFG_MAP_COLUMNS: map_cols = data[DIM_W-1:0];
        CFG_BLEND_ALPHA: blend_alpha = data[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    function int tile_edge();
      return (tile_px == 0) ? 1 : int'(tile_px);
    endfunction

    function int tile_index(int col, int row);
      int e;
      e = tile_edge();
      return (row / e) * int'(map_cols) + col / e;
    endfunction

    // a lookup past the map end never touches the store
    function bit readable(int col, int row);
      int idx;
      idx = tile_index(col, row);
      return (idx >= MAP_ENTRIES) || tile_set[idx];
    endfunction

    function logic [CH_W-1:0] blend_channel(logic [CH_W-1:0] old_ch, logic [CH_W-1:0] level);
      int a;
      int acc;
      a = (blend_alpha > ALPHA_ONE) ? int'(ALPHA_ONE) : int'(blend_alpha);
      acc = int'(old_ch) * 256 + a * (int'(level) - int'(old_ch)) + int'(ROUND_HALF);
      return acc[15:8];
    endfunction

    function logic [COLOUR_W-1:0] blend_pixel(logic [CODE_W-1:0] code,
                                              logic [COLOUR_W-1:0] old);
      logic [CH_W-1:0] level;
      case (code)
        TILE_FLOOR, TILE_ENTRANCE, TILE_EXIT: level = WHITE_LEVEL;
        TILE_WALL: level = WALL_LEVEL;
        default: return '0;
      endcase
      return {blend_channel(old[23:16], level), blend_channel(old[15:8], level),
              blend_channel(old[7:0], level)};
    endfunction

    function void note_beat(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                            logic [CODE_W-1:0] code, logic [COORD_W-1:0] col,
                            logic [COORD_W-1:0] row, logic [COLOUR_W-1:0] old);
      int idx;
      logic [CODE_W-1:0] found;
      if (cmd == CMD_WRITE) begin
        if (!tile_set[slot]) set_slots.push_back(int'(slot));
        tile_set[slot]   = 1'b1;
        tile_codes[slot] = code;
      end else begin
        idx   = tile_index(int'(col), int'(row));
        found = (idx < MAP_ENTRIES) ? tile_codes[idx] : '0;
        colours_due.push_back(blend_pixel(found, old));
      end
    endfunction

    function void check_colour(logic [COLOUR_W-1:0] got);
      logic [COLOUR_W-1:0] want;
      if (colours_due.size() == 0) begin
        errors++;
        $display("%0t tb_top: colour beat with none expected, expected none got %06h",
                 $time, got);
      end else begin
        want = colours_due.pop_front();
        checked++;
        if (got !== want) begin
          errors++;
          $display("%0t tb_top: new_colour mismatch, expected %06h got %06h",
                   $time, want, got);
        end
      end
    endfunction

    function int pending();
      return colours_due.size();
    endfunction

    // mostly aim at a written tile, now and then a raw coordinate
    function void pick_pixel(output int col, output int row);
      int e;
      int s;
      int ct;
      int rt;
      int tries;
      bit ok;
      e  = tile_edge();
      ok = 1'b0;
      if ($urandom_range(7) == 0) begin
        col = $urandom_range(COORD_MAX);
        row = $urandom_range(COORD_MAX);
        ok  = readable(col, row);
      end
      tries = 0;
      while (!ok && tries < 8) begin
        s = set_slots[$urandom_range(set_slots.size() - 1)];
        if (map_cols == 0) begin
          ct = s;
          rt = $urandom_range(COORD_MAX / e);
        end else begin
          rt = s / int'(map_cols);
          ct = s % int'(map_cols);
        end
        col = ct * e + $urandom_range(e - 1);
        row = rt * e + $urandom_range(e - 1);
        ok  = (col <= COORD_MAX) && (row <= COORD_MAX) && readable(col, row);
        tries++;
      end
      // slot 0 is always written and always reachable
      if (!ok) begin
        col = $urandom_range(e - 1);
        row = $urandom_range(e - 1);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command = '0;
  logic [SLOT_W-1:0]     in_tile_slot = '0;
  logic [CODE_W-1:0]     in_tile_code = '0;
  logic [COORD_W-1:0]    in_pixel_col = '0;
  logic [COORD_W-1:0]    in_pixel_row = '0;
  logic [COLOUR_W-1:0]   in_old_colour = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COLOUR_W-1:0]   out_new_colour;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  colour_scoreboard sb;
  int beats_in = 0;
  int settings_done = 0;
  int burst_left = 0;
  int rx_cycle = 0;
  int quiet = 0;

  tile_map_pixel_blender #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_tile_slot(in_tile_slot),
    .in_tile_code(in_tile_code),
    .in_pixel_col(in_pixel_col),
    .in_pixel_row(in_pixel_row),
    .in_old_colour(in_old_colour),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_new_colour(out_new_colour),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stall pattern rotates through four modes picked by the upper bits of rx_cycle
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle >> 8) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1));
      2: out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= ((rx_cycle % 16) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_colour(out_new_colour);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t tb_top: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [CODE_W-1:0] code, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [COLOUR_W-1:0] old);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_tile_slot  <= slot;
    in_tile_code  <= code;
    in_pixel_col  <= col;
    in_pixel_row  <= row;
    in_old_colour <= old;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(cmd, slot, code, col, row, old);
    beats_in++;
  endtask

  // unused fields of each beat carry noise
  task automatic put_tile(input int slot, input int code);
    send_beat(CMD_WRITE, SLOT_W'(slot), CODE_W'(code), COORD_W'($urandom),
              COORD_W'($urandom), COLOUR_W'($urandom));
  endtask

  task automatic shade_at(input int col, input int row, input logic [COLOUR_W-1:0] old);
    send_beat(CMD_SHADE, SLOT_W'($urandom), CODE_W'($urandom), COORD_W'(col),
              COORD_W'(row), old);
  endtask

  function automatic logic [COLOUR_W-1:0] random_colour();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return COLOUR_W'($urandom);
    endcase
  endfunction

  function automatic int random_slot();
    return ($urandom_range(3) != 0) ? $urandom_range(255) : $urandom_range(MAP_ENTRIES - 1);
  endfunction

  task automatic random_shade();
    int col;
    int row;
    sb.pick_pixel(col, row);
    shade_at(col, row, random_colour());
  endtask

  // sender bursts with random gaps, now and then a long unbroken run
  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(7) == 0) ? 200 : $urandom_range(40, 1);
    end
    burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] px, input logic [CFG_DATA_W-1:0] cols,
                           input logic [CFG_DATA_W-1:0] alpha);
    set_reg(CFG_TILE_PIXELS, px);
    set_reg(CFG_MAP_COLUMNS, cols);
    set_reg(CFG_BLEND_ALPHA, alpha);
    set_reg(CFG_UNLISTED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_done++;
  endtask

  task automatic phase_settings(input int p);
    case (p)
      0: configure(1, 64, ALPHA_ONE);
      1: configure(64, 1, 0);
      2: configure(127, 127, 9'h1ff);
      3: configure(0, 0, 1);
      4: configure(CFG_DATA_W'($urandom_range(64, 1)), CFG_DATA_W'($urandom_range(64, 1)),
                   CFG_DATA_W'($urandom_range(256)));
      default: configure(CFG_DATA_W'($urandom_range(511)), CFG_DATA_W'($urandom_range(511)),
                         CFG_DATA_W'($urandom_range(511)));
    endcase
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one tile per code, alpha zero passes old pixels through on lit tiles
    for (int k = 0; k < 8; k++) put_tile(k, k);
    put_tile(MAP_ENTRIES - 1, TILE_EXIT);
    for (int k = 0; k < 8; k++) shade_at(k * 10 + 5, 3, (k % 2) ? 24'hffffff : 24'h000000);
    // index past the map end reads black
    shade_at(COORD_MAX, COORD_MAX, 24'h5a5a5a);

    settle();
    configure(1, 64, ALPHA_ONE);
    shade_at(63, 63, 24'h000000);
    shade_at(1, 0, 24'hffffff);
    shade_at(2, 0, 24'h000000);

    // zero edge acts as one, alpha above one saturates
    settle();
    configure(0, 1, 9'd300);
    shade_at(0, 3, 24'h123456);
    shade_at(COORD_MAX, 0, 24'hfedcba);

    settle();
    configure(64, 64, 9'd128);
    shade_at(128, 0, 24'h80ff01);
    shade_at(COORD_MAX, COORD_MAX, 24'h7f0080);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      phase_settings(p);
      repeat (FILL_BEATS) begin
        pace();
        put_tile(random_slot(), $urandom_range(7));
      end
      repeat (MIX_BEATS) begin
        pace();
        if ($urandom_range(99) < 35) put_tile(random_slot(), $urandom_range(7));
        else random_shade();
      end
    end

    settle();
    $display("tb_top: %0d beats sent, %0d colours checked over %0d register settings",
             beats_in, sb.checked, settings_done);
    $display("tb_top: %0d map entries written, %0d mismatches", sb.set_slots.size(), sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
